>>> design/gec_pkg.sv
// ----------------------------------------------------------------------------
// gec_pkg: shared types and constants for the clip and echo effect
// Queue entry layout, mode and register codes, clip thresholds.
// ----------------------------------------------------------------------------
package gec_pkg;

	// one classified sample; for direct ops sample already holds the result
	typedef struct packed {
		logic               is_echo;
		logic signed [15:0] sample;
		logic               last;
	} gec_entry_t;

	localparam logic [1:0] MODE_BYPASS     = 2'd0;
	localparam logic [1:0] MODE_OVERDRIVE  = 2'd1;
	localparam logic [1:0] MODE_DISTORTION = 2'd2;
	localparam logic [1:0] MODE_ECHO       = 2'd3;

	localparam logic REG_EFFECT_MODE  = 1'b0;
	localparam logic REG_DELAY_LENGTH = 1'b1;

	localparam logic [1:0]  EFFECT_MODE_RESET  = MODE_BYPASS;
	localparam logic [14:0] DELAY_LENGTH_RESET = 15'd14400;

	localparam logic signed [16:0] SOFT_KNEE  = 17'sd8000;
	localparam logic signed [16:0] HARD_KNEE  = 17'sd3000;
	localparam logic signed [15:0] HARD_LIMIT = 16'sd12000;

	localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

	localparam int QUEUE_DEPTH = 2;

endpackage

>>> design/gec_front.sv
// ----------------------------------------------------------------------------
// gec_front: sample classifier
// Applies the clip modes directly and tags delay-mode samples for the
// echo engine while the delay length is nonzero.
// ----------------------------------------------------------------------------
module gec_front (
	input  logic               [1:0]  effect_mode,
	input  logic                      delay_off,
	input  logic signed        [15:0] sample_in,
	input  logic                      last_in_buffer,
	output gec_pkg::gec_entry_t       entry
);

	logic signed [16:0] s_ext;
	logic signed [16:0] excess;
	logic signed [16:0] soft_val;
	logic signed [15:0] soft_res;
	logic signed [15:0] hard_res;

	assign s_ext = {sample_in[15], sample_in};

	// excess over the knee, quartered toward zero
	always_comb begin
		excess   = '0;
		soft_val = s_ext;
		if (s_ext > gec_pkg::SOFT_KNEE) begin
			excess   = s_ext - gec_pkg::SOFT_KNEE;
			soft_val = gec_pkg::SOFT_KNEE + (excess >>> 2);
		end else if (s_ext < -gec_pkg::SOFT_KNEE) begin
			excess   = s_ext + gec_pkg::SOFT_KNEE + 17'sd3;
			soft_val = (excess >>> 2) - gec_pkg::SOFT_KNEE;
		end
	end

	assign soft_res = soft_val[15:0];

	always_comb begin
		if (s_ext > gec_pkg::HARD_KNEE) begin
			hard_res = gec_pkg::HARD_LIMIT;
		end else if (s_ext < -gec_pkg::HARD_KNEE) begin
			hard_res = -gec_pkg::HARD_LIMIT;
		end else begin
			hard_res = {sample_in[13:0], 2'b00};
		end
	end

	always_comb begin
		entry.last    = last_in_buffer;
		entry.is_echo = 1'b0;
		entry.sample  = sample_in;
		case (effect_mode)
			gec_pkg::MODE_OVERDRIVE: begin
				entry.sample = soft_res;
			end
			gec_pkg::MODE_DISTORTION: begin
				entry.sample = hard_res;
			end
			gec_pkg::MODE_ECHO: begin
				entry.is_echo = !delay_off;
			end
			default: begin
				entry.sample = sample_in;
			end
		endcase
	end

endmodule

>>> design/gec_queue.sv
// ----------------------------------------------------------------------------
// gec_queue: request queue between classifier and echo engine
// Small FIFO so each side can stall on its own.
// ----------------------------------------------------------------------------
module gec_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gec_pkg::gec_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output gec_pkg::gec_entry_t head_entry
);

	localparam int PTRW = (gec_pkg::QUEUE_DEPTH > 1) ? $clog2(gec_pkg::QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(gec_pkg::QUEUE_DEPTH + 1);

	gec_pkg::gec_entry_t entries_q [gec_pkg::QUEUE_DEPTH];
	logic [PTRW-1:0] wr_ptr_q;
	logic [PTRW-1:0] rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign full       = (count_q == CNTW'(gec_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(gec_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(gec_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/gec_back.sv
// ----------------------------------------------------------------------------
// gec_back: echo engine and output register
// Read-modify-write of the delay line, one request per cycle while the
// output is not stalled, with a bypass for unit delay length. Entries not
// yet written since the last clear read as zero through the wrap flag.
// ----------------------------------------------------------------------------
module gec_back #(
	parameter int DELAY_DEPTH = 16384
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic               [14:0] delay_length,
	input  logic                      cfg_clear,
	input  logic                      head_valid,
	input  gec_pkg::gec_entry_t       head_entry,
	output logic                      pop,
	output logic signed        [15:0] sample_out,
	output logic                      last_out,
	output logic                      out_valid,
	input  logic                      out_stall
);

	localparam int PW = $clog2(DELAY_DEPTH);
	localparam int LW = $clog2(DELAY_DEPTH + 1);

	logic signed [15:0] mem [DELAY_DEPTH];

	logic [LW-1:0] eff_len;
	logic [31:0]   dl32;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] pos_next;
	logic [31:0]   pos_inc;
	logic          pos_wrap;
	logic          wrapped_q;

	logic                valid_s1;
	gec_pkg::gec_entry_t entry_s1;
	logic [PW-1:0]       addr_s1;
	logic                rvalid_s1;
	logic signed [15:0]  rdata_s1;
	logic                fwd_s1;
	logic signed [15:0]  fwd_data_s1;

	logic               s1_go;
	logic               issue;
	logic               issue_echo;
	logic               wr_en;
	logic               fwd_hit;
	logic signed [15:0] delayed;
	logic signed [15:0] delayed_adj;
	logic signed [15:0] half;
	logic signed [16:0] mixed;
	logic signed [15:0] mixed_sat;
	logic signed [15:0] result;

	logic               out_valid_q;
	logic signed [15:0] sample_out_q;
	logic               last_out_q;

	assign dl32    = 32'(delay_length);
	assign eff_len = (dl32 > 32'(DELAY_DEPTH)) ? LW'(DELAY_DEPTH) : LW'(dl32);

	assign pos_inc  = 32'(pos_q) + 32'd1;
	assign pos_wrap = (pos_inc >= 32'(eff_len));
	assign pos_next = pos_wrap ? '0 : PW'(pos_inc);

	assign s1_go      = valid_s1 && (!out_valid_q || !out_stall);
	assign issue      = head_valid && (!valid_s1 || s1_go);
	assign issue_echo = issue && head_entry.is_echo;
	assign pop        = issue;
	assign wr_en      = s1_go && entry_s1.is_echo;
	// write of the previous request lands on the entry being read now
	assign fwd_hit    = issue_echo && wr_en && (addr_s1 == pos_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= result;
		end
		if (issue_echo) begin
			rdata_s1 <= mem[pos_q];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			entry_s1    <= head_entry;
			addr_s1     <= pos_q;
			rvalid_s1   <= wrapped_q;
			fwd_s1      <= fwd_hit;
			fwd_data_s1 <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			valid_s1  <= 1'b0;
		end else begin
			if (cfg_clear) begin
				pos_q     <= '0;
				wrapped_q <= 1'b0;
			end else if (issue_echo) begin
				pos_q <= pos_next;
				if (pos_wrap) begin
					wrapped_q <= 1'b1;
				end
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_comb begin
		if (!rvalid_s1) begin
			delayed = '0;
		end else if (fwd_s1) begin
			delayed = fwd_data_s1;
		end else begin
			delayed = rdata_s1;
		end
	end

	// halve toward zero
	assign delayed_adj = delayed + 16'(delayed[15]);
	assign half        = delayed_adj >>> 1;
	assign mixed       = {entry_s1.sample[15], entry_s1.sample} + {half[15], half};

	always_comb begin
		if (mixed[16] != mixed[15]) begin
			mixed_sat = mixed[16] ? gec_pkg::SAMPLE_MIN : gec_pkg::SAMPLE_MAX;
		end else begin
			mixed_sat = mixed[15:0];
		end
	end

	assign result = entry_s1.is_echo ? mixed_sat : entry_s1.sample;

	always_ff @(posedge clk) begin
		if (s1_go) begin
			sample_out_q <= result;
			last_out_q   <= entry_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sample_out = sample_out_q;
	assign last_out   = last_out_q;
	assign out_valid  = out_valid_q;

`ifndef SYNTHESIS
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(eff_len != '0) |-> (32'(pos_q) < 32'(eff_len)))
		else $error("echo position beyond delay length");

	a_fwd_unit_only: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_hit |-> (eff_len == LW'(1)))
		else $error("bypass taken with delay length above one");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_go) |=> (valid_s1 && $stable(addr_s1) && $stable(entry_s1)))
		else $error("stalled echo stage lost its request");

	a_no_issue_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_go) |-> !issue)
		else $error("request issued over a stalled stage");
`endif

endmodule

>>> design/guitar_effect_clip_and_echo_core.sv
// ----------------------------------------------------------------------------
// guitar_effect_clip_and_echo_core: clip and feedback echo effect
// Classifier, request queue and echo engine with output register.
// ----------------------------------------------------------------------------
// Path: queue, echo stage, output register. Throughput, unless the output stalls:
// one sample per cycle; the delay line takes one read and one write a cycle.
// Reset: asynchronous, active low; loads control defaults; clears position, wrap flag.
// The delay line gets no clearing pass: until the position first wraps after
// reset or a delay_length write, echo reads return zero, so it is usable at once.
module guitar_effect_clip_and_echo_core #(
	parameter int DELAY_DEPTH = 16384
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic        [14:0] cfg_data,
	input  logic signed [15:0] sample_in,
	input  logic               last_in_buffer,
	input  logic               in_valid,
	output logic               in_stall,
	output logic signed [15:0] sample_out,
	output logic               last_out,
	output logic               out_valid,
	input  logic               out_stall
);

	logic [1:0]          effect_mode_q;
	logic [14:0]         delay_length_q;
	logic                cfg_clear;
	logic                delay_off;
	gec_pkg::gec_entry_t front_entry;
	gec_pkg::gec_entry_t head_entry;
	logic                q_full;
	logic                push;
	logic                pop;
	logic                head_valid;

	assign cfg_clear = cfg_we && (cfg_index == gec_pkg::REG_DELAY_LENGTH);
	assign delay_off = (delay_length_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			effect_mode_q  <= gec_pkg::EFFECT_MODE_RESET;
			delay_length_q <= gec_pkg::DELAY_LENGTH_RESET;
		end else if (cfg_we) begin
			if (cfg_index == gec_pkg::REG_EFFECT_MODE) begin
				effect_mode_q <= cfg_data[1:0];
			end else begin
				delay_length_q <= cfg_data;
			end
		end
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	gec_front u_front (
		.effect_mode    (effect_mode_q),
		.delay_off      (delay_off),
		.sample_in      (sample_in),
		.last_in_buffer (last_in_buffer),
		.entry          (front_entry)
	);

	gec_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (front_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	gec_back #(
		.DELAY_DEPTH (DELAY_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.delay_length (delay_length_q),
		.cfg_clear    (cfg_clear),
		.head_valid   (head_valid),
		.head_entry   (head_entry),
		.pop          (pop),
		.sample_out   (sample_out),
		.last_out     (last_out),
		.out_valid    (out_valid),
		.out_stall    (out_stall)
	);

endmodule
